// File: src/cte_pkg.sv
// Shared constants and types for the palette texel expander.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package cte_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int VRAM_W        = 16;
  localparam int TEXEL_W       = 32;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  typedef enum logic [1:0] {
    DEPTH_IDX4   = 2'd0,
    DEPTH_IDX8   = 2'd1,
    DEPTH_DIRECT = 2'd2,
    DEPTH_RSVD   = 2'd3
  } depth_mode_t;

  typedef enum logic {
    WORD_PALETTE = 1'b0,
    WORD_TEXTURE = 1'b1
  } word_kind_t;

  localparam logic REG_DEPTH_MODE = 1'b0;

endpackage
`default_nettype wire

// File: src/cte_ifs.sv
// Stream interfaces for the input words and the result texels.
// Depends on cte_pkg for the payload widths.
`default_nettype none
interface cte_in_if;
  import cte_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [VRAM_W-1:0] vram_word;
  logic              restart_palette;

  modport source (output valid, output mode, output vram_word, output restart_palette,
                  input ready);
  modport sink   (input valid, input mode, input vram_word, input restart_palette,
                  output ready);
endinterface

interface cte_out_if;
  import cte_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] texel;
  logic               last;

  modport source (output valid, output texel, output last, input ready);
  modport sink   (input valid, input texel, input last, output ready);
endinterface
`default_nettype wire

// File: src/clut_texel_expander_core.sv
// Palette texel expander: turns video-memory words into 32-bit texels.
// Depends on cte_pkg and the stream interfaces in cte_ifs.sv.
//
// Input words arrive on in_stream. A palette word is written into the
// palette RAM at the write pointer as it is accepted and gives no texel.
// A texture word is split into four 4-bit or two 8-bit palette indices, or
// taken as one direct 15-bit colour, according to the depth_mode register.
// Texels leave on out_stream, one per cycle unless it stalls, with last
// set on the final texel of each word.
// The palette RAM has a single registered read port, so a texture word
// stays in the issue stage until it has issued one read per texel: four
// in 4-bit mode, two in 8-bit mode and one in direct mode. Palette words
// skip that stage; each texel passes it and the output register in turn.
// A new word is accepted in the cycle in which the previous word issues its
// last read. When out_stream stalls, the output register holds its word
// and the issue stage waits behind it, so in_stream backs up in turn.
// Reset clears the write pointer, depth_mode and all valid flags; the
// palette RAM is not cleared and must be loaded before it is used.
`default_nettype none
module clut_texel_expander_core
  import cte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  cte_in_if.sink                 in_stream,
  cte_out_if.source              out_stream,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  depth_mode_t       depth_mode_r;
  logic [PAL_AW-1:0] wr_ptr_r;
  logic [PAL_AW-1:0] wr_ptr_nxt;
  logic [PAL_AW-1:0] wr_pos;
  logic [PAL_AW-1:0] wr_mask;

  logic [VRAM_W-1:0] pal_mem [PALETTE_DEPTH];

  logic              a_valid_r;
  logic [1:0]        a_cnt_r;
  depth_mode_t       a_depth_r;
  logic [VRAM_W-1:0] a_word_r;
  logic              a_last;
  logic [PAL_AW-1:0] a_idx;
  logic              issue;

  logic              b_valid_r;
  logic              b_last_r;
  logic              b_direct_r;
  logic [VRAM_W-1:0] b_word_r;
  logic [VRAM_W-1:0] rd_data_r;
  logic [VRAM_W-1:0] colour;

  logic              in_acc;
  logic              pal_we;
  logic              tex_load;
  logic              cfg_we;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_DEPTH_MODE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DEPTH_MODE) begin
      cfg_prdata = CFG_DW'(depth_mode_r);
    end
  end

  // Input acceptance
  assign in_stream.ready = !a_valid_r || (issue && a_last);
  assign in_acc   = in_stream.valid && in_stream.ready;
  assign pal_we   = in_acc && (in_stream.mode == WORD_PALETTE);
  assign tex_load = in_acc && (in_stream.mode == WORD_TEXTURE) &&
                    (depth_mode_r != DEPTH_RSVD);

  // Write pointer wraps at sixteen entries in 4-bit mode.
  always_comb begin
    wr_mask = (depth_mode_r == DEPTH_IDX4) ? PAL_AW'(15) : '1;
    wr_pos  = in_stream.restart_palette ? '0 : (wr_ptr_r & wr_mask);
    wr_ptr_nxt = (wr_pos + PAL_AW'(1)) & wr_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= DEPTH_IDX4;
      wr_ptr_r     <= '0;
    end else begin
      if (cfg_we) begin
        depth_mode_r <= depth_mode_t'(cfg_pwdata[1:0]);
      end
      if (pal_we) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
    end
  end

  // Issue stage: one palette read per texel
  assign issue = a_valid_r && (!b_valid_r || out_stream.ready);

  always_comb begin
    case (a_depth_r)
      DEPTH_IDX4: begin
        a_last = (a_cnt_r == 2'd3);
        a_idx  = PAL_AW'(a_word_r[{a_cnt_r, 2'b00} +: 4]);
      end
      DEPTH_IDX8: begin
        a_last = (a_cnt_r == 2'd1);
        a_idx  = PAL_AW'(a_cnt_r[0] ? a_word_r[15:8] : a_word_r[7:0]);
      end
      default: begin
        a_last = 1'b1;
        a_idx  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_cnt_r   <= '0;
    end else begin
      if (tex_load) begin
        a_valid_r <= 1'b1;
        a_cnt_r   <= '0;
      end else if (issue) begin
        a_valid_r <= !a_last;
        a_cnt_r   <= a_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tex_load) begin
      a_depth_r <= depth_mode_r;
      a_word_r  <= in_stream.vram_word;
    end
  end

  // Palette RAM
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[wr_pos] <= in_stream.vram_word;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= pal_mem[a_idx];
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        b_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_last_r   <= a_last;
      b_direct_r <= (a_depth_r == DEPTH_DIRECT);
      b_word_r   <= a_word_r;
    end
  end

  assign colour = b_direct_r ? b_word_r : rd_data_r;

  assign out_stream.valid = b_valid_r;
  assign out_stream.last  = b_last_r;
  assign out_stream.texel = {(|colour) ? 8'hff : 8'h00,
                             colour[14:10], 3'b000,
                             colour[9:5],   3'b000,
                             colour[4:0],   3'b000};

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for clut_texel_expander_core: streams palette and
// texture words through the block and checks every texel against a predictor.
// Depends on cte_pkg, the stream interfaces in cte_ifs.sv and the core itself.
`default_nettype none
module testbench;
  import cte_pkg::*;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic               last;
  } texel_word_t;

  localparam logic [VRAM_W-1:0] DIRECTED_PALETTE [16] = '{
    16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h001F, 16'h03E0, 16'h7C00, 16'h0001,
    16'h0400, 16'h5555, 16'h2AAA, 16'h0020, 16'h8001, 16'h1234, 16'h4321, 16'h7BDE
  };
  localparam depth_mode_t PHASE_DEPTH [8] = '{
    DEPTH_IDX4, DEPTH_IDX8, DEPTH_DIRECT, DEPTH_IDX8,
    DEPTH_IDX4, DEPTH_DIRECT, DEPTH_IDX8, DEPTH_IDX4
  };

  class texel_scoreboard;
    logic [VRAM_W-1:0] palette [PALETTE_DEPTH];
    logic [PAL_AW-1:0] write_ptr;
    depth_mode_t       depth;
    texel_word_t       expected_texels [$];
    int                mismatches;

    function new();
      write_ptr  = '0;
      depth      = DEPTH_IDX4;
      mismatches = 0;
    endfunction

    function void set_depth(depth_mode_t d);
      depth = d;
    endfunction

    function int pending();
      return expected_texels.size();
    endfunction

    function logic [TEXEL_W-1:0] colour_texel(logic [VRAM_W-1:0] c);
      return {(c != '0) ? 8'hFF : 8'h00, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
    endfunction

    function void push_texel(logic [VRAM_W-1:0] c, logic last);
      texel_word_t t;
      t.texel = colour_texel(c);
      t.last  = last;
      expected_texels.push_back(t);
    endfunction

    function void note_word(word_kind_t kind, logic [VRAM_W-1:0] w, logic restart);
      int wrap;
      int pos;
      if (kind == WORD_PALETTE) begin
        wrap = (depth == DEPTH_IDX4) ? 16 : PALETTE_DEPTH;
        pos = restart ? 0 : int'(write_ptr) % wrap;
        palette[PAL_AW'(pos)] = w;
        write_ptr = PAL_AW'((pos + 1) % wrap);
      end else begin
        case (depth)
          DEPTH_IDX4: begin
            push_texel(palette[PAL_AW'(w[3:0])], 1'b0);
            push_texel(palette[PAL_AW'(w[7:4])], 1'b0);
            push_texel(palette[PAL_AW'(w[11:8])], 1'b0);
            push_texel(palette[PAL_AW'(w[15:12])], 1'b1);
          end
          DEPTH_IDX8: begin
            push_texel(palette[PAL_AW'(w[7:0])], 1'b0);
            push_texel(palette[PAL_AW'(w[15:8])], 1'b1);
          end
          DEPTH_DIRECT: begin
            push_texel(w, 1'b1);
          end
          default: begin
          end
        endcase
      end
    endfunction

    function void check_texel(logic [TEXEL_W-1:0] texel, logic last);
      texel_word_t t;
      if (expected_texels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected texel %h last %0b with nothing outstanding.", texel, last);
      end else begin
        t = expected_texels.pop_front();
        if (t.texel !== texel || t.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Texel mismatch: expected %h last %0b, got %h last %0b.",
                     t.texel, t.last, texel, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int sender_pct;
  int stall_pct;
  texel_scoreboard sb;

  cte_in_if  in_if ();
  cte_out_if out_if ();

  clut_texel_expander_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_if),
    .out_stream  (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** clut_texel_expander_core: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_word(word_kind_t'(in_if.mode), in_if.vram_word, in_if.restart_palette);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_texel(out_if.texel, out_if.last);
  end

  task automatic set_idling(int p);
    case (p % 4)
      0: begin sender_pct = 0;  stall_pct = 0;  end
      1: begin sender_pct = 48; stall_pct = 0;  end
      2: begin sender_pct = 0;  stall_pct = 48; end
      default: begin sender_pct = 10; stall_pct = 10; end
    endcase
  endtask

  task automatic send_word(word_kind_t kind, logic [VRAM_W-1:0] w, logic restart);
    if ($urandom_range(99) < sender_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_pct);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= kind;
    in_if.vram_word       <= w;
    in_if.restart_palette <= restart;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stops sending, waits for every outstanding texel, then lets the block settle.
  task automatic drain(int settle_cycles);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic write_depth(depth_mode_t d);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(REG_DEPTH_MODE));
    cfg_pwdata  <= CFG_DW'(d);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_depth(d);
  endtask

  initial begin
    sb = new();
    sender_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = WORD_PALETTE;
    in_if.vram_word = '0;
    in_if.restart_palette = 1'b0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A small palette in 4-bit mode, then its wrap back to entry zero.
    write_depth(DEPTH_IDX4);
    send_word(WORD_PALETTE, DIRECTED_PALETTE[0], 1'b1);
    for (int i = 1; i < 16; i++) send_word(WORD_PALETTE, DIRECTED_PALETTE[i], 1'b0);
    send_word(WORD_TEXTURE, 16'h3210, 1'b0);
    send_word(WORD_TEXTURE, 16'hFFFF, 1'b0);
    send_word(WORD_PALETTE, 16'h0C63, 1'b0);
    send_word(WORD_TEXTURE, 16'h0000, 1'b0);
    drain(8);
    write_depth(DEPTH_DIRECT);
    send_word(WORD_TEXTURE, 16'h0000, 1'b0);
    send_word(WORD_TEXTURE, 16'h8000, 1'b0);
    send_word(WORD_TEXTURE, 16'h7FFF, 1'b0);
    drain(8);
    write_depth(DEPTH_IDX8);
    send_word(WORD_TEXTURE, 16'h0F01, 1'b0);
    drain(8);
    // The unused depth code still stores palette words but expands nothing.
    write_depth(DEPTH_RSVD);
    send_word(WORD_PALETTE, 16'hFFFF, 1'b0);
    send_word(WORD_TEXTURE, 16'hFFFF, 1'b0);

    // Load the whole palette so that any 8-bit index is safe afterwards.
    drain(8);
    write_depth(DEPTH_IDX8);
    set_idling(3);
    send_word(WORD_PALETTE, VRAM_W'($urandom), 1'b1);
    for (int i = 1; i < PALETTE_DEPTH; i++)
      send_word(WORD_PALETTE, VRAM_W'($urandom), 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain(8);
      write_depth(PHASE_DEPTH[p]);
      set_idling(p);
      for (int k = 0; k < 19; k++) begin
        if (p == 1 && k == 9) drain(0);
        if ($urandom_range(99) < 25)
          send_word(WORD_PALETTE, VRAM_W'($urandom), $urandom_range(7) == 0);
        else
          send_word(WORD_TEXTURE, VRAM_W'($urandom), 1'($urandom_range(1)));
      end
    end

    drain(10);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** clut_texel_expander_core: PASSED **");
    end else begin
      $display("** clut_texel_expander_core: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
src/cte_pkg.sv
src/cte_ifs.sv
src/clut_texel_expander_core.sv
dv/testbench.sv
